// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the buddy allocator RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, muted during reset
`define ASSERT_IMPLIES(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// next-cycle implication, muted during reset
`define ASSERT_NEXT(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

// ===== rtl/bpa_pkg.sv =====
// Package of the buddy page allocator: payload structs, codes, FSM states,
// and the command/status structs between controller and datapath. No dependencies.
package bpa_pkg;

    localparam int LEAF_PAGES_DEF = 256;
    localparam int PAGE_BYTES_DEF = 4096;
    localparam int ADDR_W         = 48;
    localparam int AMT_W          = 32;

    localparam logic [1:0] MODE_BYTES = 2'd0;
    localparam logic [1:0] MODE_PAGES = 2'd1;
    localparam logic [1:0] MODE_FREE  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_FIT   = 2'd1;
    localparam logic [1:0] ST_BAD_FREE = 2'd2;

    typedef struct packed {
        logic [1:0]        mode;
        logic [AMT_W-1:0]  amount;
        logic [ADDR_W-1:0] free_address;
    } t_in;

    typedef struct packed {
        logic [ADDR_W-1:0] block_address;
        logic [1:0]        status;
    } t_out;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_SIZE,
        S_ROOT_RD,
        S_ROOT_CHK,
        S_DESC_RD,
        S_DESC_CHK,
        S_TAKE,
        S_UP_RD,
        S_UP_WR,
        S_MUL,
        S_RANGE,
        S_DIV,
        S_DIV_END,
        S_CLIMB_RD,
        S_CLIMB_CHK,
        S_FIN
    } t_state;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_CLR,
        DP_LOAD,
        DP_SIZE_STEP,
        DP_ROOT_RD,
        DP_DESC_RD,
        DP_DESC_STEP,
        DP_TAKE,
        DP_UP_RD,
        DP_UP_WR,
        DP_MUL,
        DP_DIV_INIT,
        DP_DIV_STEP,
        DP_CLIMB_INIT,
        DP_CLIMB_RD,
        DP_CLIMB_UP,
        DP_RESTORE,
        DP_RES
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic [1:0] status;
        logic       grant;
    } t_cmd;

    typedef struct packed {
        logic [1:0] mode;
        logic       clr_done;
        logic       amt_zero;
        logic       amt_fits;
        logic       k_last;
        logic       hit_a;
        logic       hit_b;
        logic       leaf_next;
        logic       at_root;
        logic       node_zero;
        logic       node_odd;
        logic       rem_in_range;
        logic       rem_zero;
        logic       out_free;
    } t_stat;

endpackage

// ===== rtl/buddy_page_allocator.sv =====
// Top level of the buddy page allocator: controller plus datapath.
// Depends on bpa_pkg, bpa_ctrl and bpa_datapath.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------
//  input    | i_in_valid / o_in_ready   | i_in  (mode, amount, free_address)
//  output   | o_out_valid / i_out_ready | o_out (block_address, status)
//  config   | i_cfg_wr_en               | i_cfg_data (region_base)
//
// One word at a time, taken only while idle. Allocate: sizing steps, a root read,
// a read and a check per descent level, the take, a read and a write per level
// climbed back, the address multiply and the result; a request for one page walks
// the most levels. Free: range check, division, a read and a check per node on the
// climb, a read and a write per merge level and the result; a bad address ends
// early. The node mask memory (one write, two registered reads) sets the per-level
// cost. After reset a clearing pass writes all 2*leaf-1 nodes before the first word
// is taken. A stalled output holds the last step only.
module buddy_page_allocator
    import bpa_pkg::*;
#(
    parameter int LEAF_PAGES = LEAF_PAGES_DEF,
    parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [ADDR_W-1:0] i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in               i_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out              o_out
);

    t_cmd  cmd;
    t_stat stat;

    bpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bpa_datapath #(
        .LEAF_PAGES (LEAF_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

// ===== rtl/bpa_ctrl.sv =====
// Controller of the buddy page allocator: sequences sizing, tree walks and result.
// Depends on bpa_pkg and assert_macros.svh; drives bpa_datapath by command struct.
`include "assert_macros.svh"

module bpa_ctrl
    import bpa_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state     r_state, n_state;
    logic [1:0] r_status, n_status;
    logic       r_grant, n_grant;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_status <= ST_OK;
            r_grant  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
            r_grant  <= n_grant;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        n_grant  = r_grant;
        unique case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                n_grant = 1'b0;
                unique case (i_stat.mode)
                    MODE_BYTES, MODE_PAGES: n_state = S_SIZE;
                    MODE_FREE:              n_state = S_RANGE;
                    default: begin
                        n_state  = S_FIN;
                        n_status = ST_NO_FIT;
                    end
                endcase
            end
            S_SIZE: begin
                if (i_stat.amt_zero || (!i_stat.amt_fits && i_stat.k_last)) begin
                    n_state  = S_FIN;
                    n_status = ST_NO_FIT;
                end else if (i_stat.amt_fits) begin
                    n_state = S_ROOT_RD;
                end
            end
            S_ROOT_RD: n_state = S_ROOT_CHK;
            S_ROOT_CHK: begin
                if (!i_stat.hit_a) begin
                    n_state  = S_FIN;
                    n_status = ST_NO_FIT;
                end else begin
                    n_state = S_DESC_RD;
                end
            end
            S_DESC_RD: n_state = S_DESC_CHK;
            S_DESC_CHK: begin
                if ((!i_stat.hit_a && !i_stat.hit_b) || i_stat.leaf_next) n_state = S_TAKE;
                else n_state = S_DESC_RD;
            end
            S_TAKE: begin
                n_state = i_stat.at_root ? S_MUL : S_UP_RD;
            end
            S_UP_RD: n_state = S_UP_WR;
            S_UP_WR: begin
                if (!i_stat.at_root) begin
                    n_state = S_UP_RD;
                end else if (i_stat.mode == MODE_FREE) begin
                    n_state  = S_FIN;
                    n_status = ST_OK;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state  = S_FIN;
                n_status = ST_OK;
                n_grant  = 1'b1;
            end
            S_RANGE: begin
                if (!i_stat.rem_in_range) begin
                    n_state  = S_FIN;
                    n_status = ST_BAD_FREE;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: n_state = S_DIV_END;
            S_DIV_END: begin
                if (!i_stat.rem_zero) begin
                    n_state  = S_FIN;
                    n_status = ST_BAD_FREE;
                end else begin
                    n_state = S_CLIMB_RD;
                end
            end
            S_CLIMB_RD: n_state = S_CLIMB_CHK;
            S_CLIMB_CHK: begin
                if (i_stat.node_zero) begin
                    if (i_stat.at_root) begin
                        n_state  = S_FIN;
                        n_status = ST_OK;
                    end else begin
                        n_state = S_UP_RD;
                    end
                end else if (i_stat.node_odd) begin
                    n_state  = S_FIN;
                    n_status = ST_BAD_FREE;
                end else begin
                    n_state = S_CLIMB_RD;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.op     = DP_NOP;
        o_cmd.status = r_status;
        o_cmd.grant  = r_grant;
        o_in_ready   = 1'b0;
        unique case (r_state)
            S_CLEAR: o_cmd.op = DP_CLR;
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd.op = DP_LOAD;
            end
            S_SIZE: begin
                if (!i_stat.amt_zero && !i_stat.amt_fits && !i_stat.k_last)
                    o_cmd.op = DP_SIZE_STEP;
            end
            S_ROOT_RD:  o_cmd.op = DP_ROOT_RD;
            S_DESC_RD:  o_cmd.op = DP_DESC_RD;
            S_DESC_CHK: o_cmd.op = DP_DESC_STEP;
            S_TAKE:     o_cmd.op = DP_TAKE;
            S_UP_RD:    o_cmd.op = DP_UP_RD;
            S_UP_WR:    o_cmd.op = DP_UP_WR;
            S_MUL:      o_cmd.op = DP_MUL;
            S_RANGE: begin
                if (i_stat.rem_in_range) o_cmd.op = DP_DIV_INIT;
            end
            S_DIV: o_cmd.op = DP_DIV_STEP;
            S_DIV_END: begin
                if (i_stat.rem_zero) o_cmd.op = DP_CLIMB_INIT;
            end
            S_CLIMB_RD: o_cmd.op = DP_CLIMB_RD;
            S_CLIMB_CHK: begin
                if (i_stat.node_zero) o_cmd.op = DP_RESTORE;
                else if (!i_stat.node_odd) o_cmd.op = DP_CLIMB_UP;
            end
            S_FIN: begin
                if (i_stat.out_free) o_cmd.op = DP_RES;
            end
            default: o_cmd.op = DP_NOP;
        endcase
    end

    `ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state != S_IDLE, "accepted word did not start work")
    `ASSERT_IMPLIES(a_grant_only_ok, i_clk, i_rst_n, o_cmd.op == DP_RES && o_cmd.grant, o_cmd.status == ST_OK, "grant with failing status")
    `ASSERT_IMPLIES(a_ready_only_idle, i_clk, i_rst_n, o_in_ready, r_state == S_IDLE, "input ready outside idle")

endmodule

// ===== rtl/bpa_datapath.sv =====
// Datapath of the buddy page allocator: node mask memory, walk registers,
// sizing and division steps, result register. Depends on bpa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bpa_datapath
    import bpa_pkg::*;
#(
    parameter int LEAF_PAGES = LEAF_PAGES_DEF,
    parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [ADDR_W-1:0] i_cfg_data,
    input  t_in               i_in,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out              o_out
);

    localparam int L   = $clog2(LEAF_PAGES + 1) - 1;   // log2 of leaf count
    localparam int LC  = 1 << L;
    localparam int NW  = L + 1;                        // node index width
    localparam int MW  = L + 1;                        // size mask width
    localparam int KW  = $clog2(L + 2);
    localparam int PBW = $clog2(PAGE_BYTES + 1);
    localparam int PRW = L + PBW;
    localparam int SH  = L + PBW;                      // reciprocal scale
    localparam int RW  = L + 2;                        // reciprocal width
    localparam int QW  = L + 1;                        // quotient estimate width
    localparam logic [ADDR_W-1:0] RANGE_END = ADDR_W'(LC) * ADDR_W'(PAGE_BYTES);
    localparam logic [RW-1:0] RECIP =
        RW'(((64'd1 << SH) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES));

    logic [MW-1:0] r_mem [2*LC];
    logic [MW-1:0] r_rd_a, r_rd_b;

    logic [ADDR_W-1:0] r_base;
    logic [1:0]        r_mode;
    logic [AMT_W-1:0]  r_amount;
    logic [ADDR_W-1:0] r_cmp, r_rem;
    logic [KW-1:0]     r_k, r_h;
    logic [NW-1:0]     r_i;
    logic [L-1:0]      r_pos;
    logic [QW-1:0]     r_q;
    logic [PRW-1:0]    r_prod;
    logic [NW-1:0]     r_c, r_lo;
    logic [MW-1:0]     r_cm;
    logic              r_out_valid;
    t_out              r_out;

    logic              we;
    logic [NW-1:0]     wa, ra, rb;
    logic [MW-1:0]     wd, need, full_c, full_p, merged;
    logic [NW-1:0]     shifted;
    logic [PRW+RW-1:0] recip_prod;
    logic              out_free;

    assign need    = MW'(1) << r_k;
    assign full_c  = MW'(((MW+1)'(1) << r_h) - (MW+1)'(1));
    assign full_p  = MW'(((MW+1)'(1) << (r_h + 1'b1)) - (MW+1)'(1));
    assign merged  = (r_rd_a == full_c && r_rd_b == full_c) ? full_p : (r_rd_a | r_rd_b);
    assign shifted = NW'(r_i << r_h);
    // quotient estimate, exact whenever the offset is a whole number of pages
    assign recip_prod = (PRW+RW)'(r_rem[PRW-1:0]) * (PRW+RW)'(RECIP);
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        we = 1'b0;
        wa = r_i;
        wd = '0;
        ra = '0;
        rb = '0;
        unique case (i_cmd.op)
            DP_CLR: begin
                we = 1'b1;
                wa = r_c;
                wd = r_cm;
            end
            DP_ROOT_RD:  ra = NW'(1);
            DP_DESC_RD: begin
                ra = NW'({r_i, 1'b1});
                rb = NW'({r_i, 1'b0});
            end
            DP_TAKE:     we = 1'b1;
            DP_UP_RD: begin
                ra = {r_i[NW-1:1], 1'b0};
                rb = {r_i[NW-1:1], 1'b1};
            end
            DP_UP_WR: begin
                we = 1'b1;
                wd = merged;
            end
            DP_CLIMB_RD: ra = r_i;
            DP_RESTORE: begin
                we = 1'b1;
                wd = full_p;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[wa] <= wd;
        r_rd_a <= r_mem[ra];
        r_rd_b <= r_mem[rb];
    end

    // clearing sweep runs from the last leaf down to the root
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c  <= '1;
            r_lo <= NW'(LC);
            r_cm <= MW'(1);
        end else if (i_cmd.op == DP_CLR) begin
            r_c <= r_c - 1'b1;
            if (r_c == r_lo) begin
                r_lo <= r_lo >> 1;
                r_cm <= MW'({r_cm, 1'b1});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_base <= '0;
        else if (i_cfg_wr_en) r_base <= i_cfg_data;
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_LOAD: begin
                r_mode   <= i_in.mode;
                r_amount <= i_in.amount;
                r_rem    <= i_in.free_address - r_base;
                r_cmp    <= (i_in.mode == MODE_PAGES) ? ADDR_W'(1) : ADDR_W'(PAGE_BYTES);
                r_k      <= '0;
            end
            DP_SIZE_STEP: begin
                r_cmp <= r_cmp << 1;
                r_k   <= r_k + 1'b1;
            end
            DP_ROOT_RD: begin
                r_i <= NW'(1);
                r_h <= KW'(L);
            end
            DP_DESC_STEP: begin
                if (|(r_rd_a & need)) begin
                    r_i <= NW'({r_i, 1'b1});
                    r_h <= r_h - 1'b1;
                end else if (|(r_rd_b & need)) begin
                    r_i <= NW'({r_i, 1'b0});
                    r_h <= r_h - 1'b1;
                end
            end
            // hold the page offset of the taken node for the address
            DP_TAKE: r_pos <= shifted[L-1:0];
            DP_UP_RD, DP_CLIMB_UP: begin
                r_i <= r_i >> 1;
                r_h <= r_h + 1'b1;
            end
            DP_MUL: r_prod <= PRW'(r_pos) * PRW'(PAGE_BYTES);
            DP_DIV_INIT: r_q <= QW'(recip_prod >> SH);
            DP_DIV_STEP: r_prod <= PRW'(r_q) * PRW'(PAGE_BYTES);
            DP_CLIMB_INIT: begin
                r_i <= {1'b1, r_q[L-1:0]};
                r_h <= '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == DP_RES) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DP_RES) begin
            r_out.block_address <= i_cmd.grant ? r_base + ADDR_W'(r_prod) : '0;
            r_out.status        <= i_cmd.status;
        end
    end

    always_comb begin
        o_stat.mode         = r_mode;
        o_stat.clr_done     = r_c == NW'(1);
        o_stat.amt_zero     = r_amount == '0;
        o_stat.amt_fits     = ADDR_W'(r_amount) <= r_cmp;
        o_stat.k_last       = r_k == KW'(L);
        o_stat.hit_a        = |(r_rd_a & need);
        o_stat.hit_b        = |(r_rd_b & need);
        o_stat.leaf_next    = r_i >= NW'(LC >> 1);
        o_stat.at_root      = r_i == NW'(1);
        o_stat.node_zero    = r_rd_a == '0;
        o_stat.node_odd     = r_i[0];
        o_stat.rem_in_range = r_rem < RANGE_END;
        o_stat.rem_zero     = ADDR_W'(r_prod) == r_rem;
        o_stat.out_free     = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `ASSERT_IMPLIES(a_res_into_free_reg, i_clk, i_rst_n, i_cmd.op == DP_RES, out_free, "result word overwrites a pending one")
    `ASSERT_IMPLIES(a_take_in_tree, i_clk, i_rst_n, i_cmd.op == DP_TAKE, r_i != '0, "taking node outside the tree")
    `ASSERT_IMPLIES(a_merge_not_at_leaf, i_clk, i_rst_n, i_cmd.op == DP_UP_WR, r_h != '0, "merge written at leaf height")

endmodule

// ===== sim/bpa_checker.sv =====
`timescale 1ns / 100ps
// Checker for the buddy page allocator: watches both channels, predicts each
// result word from its own tree model and compares. Depends on bpa_pkg.
module bpa_checker
    import bpa_pkg::*;
#(
    parameter int LEAF_PAGES = LEAF_PAGES_DEF,
    parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [ADDR_W-1:0] i_cfg_data,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  t_in               i_in,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  t_out              i_out,
    output int                o_fail_count,
    output int                o_pending
);

    // largest power of two that fits in the page count
    localparam int LEAVES = 1 << ($clog2(LEAF_PAGES + 1) - 1);

    logic [31:0]       tree_mask [2*LEAVES];
    logic [ADDR_W-1:0] base_addr;
    t_out              grant_queue [$];
    int                fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = grant_queue.size();

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $time, what);
        fail_count++;
    endtask

    function automatic void tree_reset();
        for (int n = LEAVES; n < 2*LEAVES; n++) tree_mask[n] = 1;
        for (int n = LEAVES-1; n >= 1; n--) tree_mask[n] = (tree_mask[2*n] << 1) | 1;
        tree_mask[0] = 0;
    endfunction

    function automatic t_out take_block(input longint unsigned pages);
        t_out r;
        longint unsigned need, off;
        int n, span;
        r = '0;
        r.status = ST_NO_FIT;
        if (pages == 0 || pages > LEAVES) return r;
        need = 1;
        while (need < pages) need <<= 1;
        if ((tree_mask[1] & need) == 0) return r;
        n = 1; span = LEAVES; off = 0;
        while (n < LEAVES) begin
            if (tree_mask[2*n+1] & need) begin
                off += span >> 1; n = 2*n+1;
            end else if (tree_mask[2*n] & need) begin
                n = 2*n;
            end else begin
                break;
            end
            span >>= 1;
        end
        tree_mask[n] = 0;
        for (int j = n >> 1; j >= 1; j >>= 1) tree_mask[j] = tree_mask[2*j] | tree_mask[2*j+1];
        r.block_address = base_addr + ADDR_W'(off * PAGE_BYTES);
        r.status = ST_OK;
        return r;
    endfunction

    function automatic t_out release_block(input logic [ADDR_W-1:0] addr);
        t_out r;
        logic [ADDR_W-1:0] off;
        longint unsigned pg;
        int n;
        logic [31:0] span, full;
        r = '0;
        r.status = ST_BAD_FREE;
        off = addr - base_addr;
        if (off % PAGE_BYTES != 0) return r;
        pg = off / PAGE_BYTES;
        if (pg >= LEAVES) return r;
        n = LEAVES + int'(pg);
        span = 1;
        while (tree_mask[n] != 0) begin
            if (n & 1) return r;
            n >>= 1; span <<= 1;
        end
        tree_mask[n] = (span << 1) - 1;
        for (int j = n >> 1; j >= 1; j >>= 1) begin
            full = (span << 1) - 1;
            if (tree_mask[2*j] == full && tree_mask[2*j+1] == full)
                tree_mask[j] = (span << 2) - 1;
            else
                tree_mask[j] = tree_mask[2*j] | tree_mask[2*j+1];
            span <<= 1;
        end
        r.status = ST_OK;
        return r;
    endfunction

    function automatic t_out predict_grant(input t_in w);
        t_out r;
        r = '0;
        case (w.mode)
            MODE_BYTES: r = take_block((64'(w.amount) + PAGE_BYTES - 1) / PAGE_BYTES);
            MODE_PAGES: r = take_block(64'(w.amount));
            MODE_FREE:  r = release_block(w.free_address);
            default:    r.status = ST_NO_FIT;
        endcase
        return r;
    endfunction

    initial fail_count = 0;

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            tree_reset();
            base_addr = '0;
            grant_queue.delete();
        end else begin
            if (i_cfg_wr_en) base_addr = i_cfg_data;
            if (i_in_valid && i_in_ready) grant_queue.push_back(predict_grant(i_in));
            if (i_out_valid && i_out_ready) begin
                if (grant_queue.size() == 0) begin
                    report("result word with nothing expected");
                end else begin
                    want = grant_queue.pop_front();
                    if (i_out.block_address !== want.block_address)
                        report($sformatf("block_address %h, want %h",
                                         i_out.block_address, want.block_address));
                    if (i_out.status !== want.status)
                        report($sformatf("status %0d, want %0d", i_out.status, want.status));
                end
            end
        end
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the buddy page allocator: stimulus, idling and verdict.
// Depends on bpa_pkg, buddy_page_allocator and bpa_checker.
module tb;
    import bpa_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic              i_clk = 0;
    logic              i_rst_n = 0;
    logic              cfg_wr_en = 0;
    logic [ADDR_W-1:0] cfg_data = '0;
    logic              in_valid = 0;
    logic              in_ready;
    t_in               in_word = '0;
    logic              out_valid;
    logic              out_ready = 0;
    t_out              out_word;
    int                fail_count, pending;
    int                send_idle_pct = 0, recv_idle_pct = 0;
    int                quiet_cycles = 0;
    logic [ADDR_W-1:0] base_addr = '0;
    logic [ADDR_W-1:0] granted [$];

    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    buddy_page_allocator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(cfg_wr_en), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in(in_word),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out(out_word)
    );

    bpa_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(cfg_wr_en), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in(in_word),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out(out_word),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver stalls at random; keep a list of granted addresses for frees
    always @(posedge i_clk) begin
        if (out_valid && out_ready && out_word.status == ST_OK && out_word.block_address != 0)
            granted.push_back(out_word.block_address);
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired at %0t", $time);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // valid stays up between back-to-back words; drop it only for an idle gap
    task automatic send_word(input logic [1:0] m, input logic [31:0] amt,
                             input logic [ADDR_W-1:0] fa);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        in_valid <= 1;
        in_word  <= '{mode: m, amount: amt, free_address: fa};
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    task automatic drain_and_config(input logic [ADDR_W-1:0] value);
        in_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        cfg_wr_en <= 1;
        cfg_data  <= value;
        @(posedge i_clk);
        cfg_wr_en <= 0;
        base_addr = value;
        granted.delete();
    endtask

    // mostly alloc/free traffic against live blocks, some noise
    task automatic random_traffic(input int count);
        int pick, idx;
        logic [ADDR_W-1:0] a;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            if (pick < 30)
                send_word(MODE_PAGES, $urandom_range(0, 3) == 0 ? $urandom_range(1, 256)
                                                               : $urandom_range(1, 16), '0);
            else if (pick < 50)
                send_word(MODE_BYTES, $urandom_range(0, 3) == 0 ? $urandom
                                                               : $urandom_range(1, 65536), '0);
            else if (pick < 85 && granted.size() > 0) begin
                idx = $urandom_range(granted.size() - 1);
                a = granted[idx];
                granted.delete(idx);
                send_word(MODE_FREE, $urandom, a);
            end else if (pick < 92)
                send_word(MODE_FREE, $urandom,
                          base_addr + ADDR_W'($urandom_range(0, 300)) * 4096);
            else if (pick < 96)
                send_word(MODE_FREE, $urandom, {$urandom, $urandom});
            else
                send_word(2'd3, $urandom, {$urandom, $urandom});
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        // directed: extremes and each special case
        send_word(MODE_PAGES, 0, '0);
        send_word(MODE_BYTES, 0, '0);
        send_word(MODE_PAGES, 257, '0);
        send_word(MODE_PAGES, 32'hFFFF_FFFF, '0);
        send_word(MODE_BYTES, 32'hFFFF_FFFF, '0);
        send_word(MODE_BYTES, 1, '0);
        send_word(MODE_BYTES, 4097, '0);
        send_word(MODE_PAGES, 3, '0);
        send_word(MODE_PAGES, 256, '0);
        send_word(MODE_FREE, 0, 48'h1);
        send_word(MODE_FREE, 0, 48'd256 * 4096);
        send_word(MODE_FREE, 0, 48'hFFFF_FFFF_FFFF);
        send_word(MODE_FREE, 0, 48'd255 * 4096);
        send_word(MODE_FREE, 0, 48'd254 * 4096);
        send_word(MODE_FREE, 0, 48'd252 * 4096);
        send_word(2'd3, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_word(MODE_PAGES, 256, '0);
        send_word(MODE_PAGES, 1, '0);
        send_word(MODE_FREE, 0, '0);
        drain_and_config(48'hFFFF_FFFF_F000);
        send_word(MODE_PAGES, 2, '0);
        send_word(MODE_FREE, 0, 48'hFFFF_FFFF_F000);
        send_word(MODE_FREE, 0, '0);

        send_idle_pct = 20; recv_idle_pct = 70;
        random_traffic(530);
        drain_and_config({$urandom, $urandom} & 48'hFFFF_FFFF_F000);
        send_idle_pct = 70; recv_idle_pct = 20;
        random_traffic(530);
        drain_and_config({$urandom, $urandom});
        send_idle_pct = 0; recv_idle_pct = 0;
        random_traffic(270);
        drain_and_config('0);
        random_traffic(270);

        in_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
